[hdl/cmfs_pkg.sv]
// Shared types, widths and constants for the cube map face select unit.
// Depends on nothing; every other file in hdl but cmfs_checker imports it.
package cmfs_pkg;

    // Field widths.
    localparam int DIR_W   = 16;
    localparam int MAG_W   = 17;
    localparam int FSIZE_W = 13;
    localparam int COORD_W = 12;
    localparam int INDEX_W = 24;
    localparam int QUOT_W  = 13;
    localparam int REM_W   = 16;
    localparam int SUM_W   = 17;
    localparam int PROD_W  = 29;
    localparam int DIV_W   = 17;

    // Face size limits.
    localparam int MAX_FACE_SIZE   = 4096;
    localparam int FACE_SIZE_RESET = 256;

    // Cube faces.
    typedef enum logic [2:0] {
        FACE_POS_X = 3'd0,
        FACE_NEG_X = 3'd1,
        FACE_POS_Y = 3'd2,
        FACE_NEG_Y = 3'd3,
        FACE_POS_Z = 3'd4,
        FACE_NEG_Z = 3'd5
    } face_t;

    // One lane of the restoring divider: partial remainder, numerator bits
    // still to be shifted in, and quotient bits found so far.
    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [QUOT_W-1:0] low;
        logic [QUOT_W-1:0] quo;
    } cmfs_lane_t;

    // Word carried through the divider stages.
    typedef struct packed {
        logic              zero;
        face_t             face;
        logic [DIV_W-1:0]  div;
        cmfs_lane_t        col;
        cmfs_lane_t        row;
    } cmfs_div_t;

    // Effective face size, saturated to the supported range.
    function automatic logic [FSIZE_W-1:0] sat_face_size(input logic [FSIZE_W-1:0] v);
        logic [FSIZE_W-1:0] r;
        if (v == '0)
            r = FSIZE_W'(1);
        else if (v > FSIZE_W'(MAX_FACE_SIZE))
            r = FSIZE_W'(MAX_FACE_SIZE);
        else
            r = v;
        return r;
    endfunction

endpackage

[hdl/cmfs_major_axis.sv]
// Front of the pipeline: major axis and face choice, numerator offset and
// the scaling multiply. Three register stages. Depends on cmfs_pkg.
module cmfs_major_axis
    import cmfs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic signed [DIR_W-1:0]  dir_x,
    input  logic signed [DIR_W-1:0]  dir_y,
    input  logic signed [DIR_W-1:0]  dir_z,
    input  logic [FSIZE_W-1:0]       size_eff,
    output logic                     out_valid,
    output cmfs_div_t                out_word
);

    // Stage 1 signals.
    logic signed [MAG_W-1:0] xs, ys, zs;
    logic [MAG_W-1:0]        ax, ay, az;
    logic [MAG_W-1:0]        ma_next;
    logic signed [MAG_W-1:0] sc_next, tc_next;
    face_t                   face_next;
    logic                    zero_next;

    logic                    v1_reg;
    logic [MAG_W-1:0]        ma_reg;
    logic signed [MAG_W-1:0] sc_reg, tc_reg;
    face_t                   face1_reg;
    logic                    zero1_reg;

    // Stage 2 signals.
    logic signed [SUM_W:0]   sum_c, sum_r;
    logic                    v2_reg;
    logic [SUM_W-1:0]        sumc_reg, sumr_reg;
    logic [DIV_W-1:0]        div_reg;
    face_t                   face2_reg;
    logic                    zero2_reg;

    // Stage 3 signals.
    logic [PROD_W:0]         prod_c, prod_r;
    logic                    v3_reg;
    cmfs_div_t               word_next, word_reg;

    // Magnitudes, with the most negative value widened so it stays exact.
    always_comb
    begin
        xs = MAG_W'(dir_x);
        ys = MAG_W'(dir_y);
        zs = MAG_W'(dir_z);
        ax = xs[MAG_W-1] ? MAG_W'(-xs) : MAG_W'(xs);
        ay = ys[MAG_W-1] ? MAG_W'(-ys) : MAG_W'(ys);
        az = zs[MAG_W-1] ? MAG_W'(-zs) : MAG_W'(zs);
    end

    // Major axis with ties going to x, then y; face and numerators follow.
    always_comb
    begin
        zero_next = (dir_x == '0) && (dir_y == '0) && (dir_z == '0);
        if (ax >= ay && ax >= az)
        begin
            ma_next = ax;
            tc_next = -ys;
            if (!xs[MAG_W-1] && !zero_next)
            begin
                face_next = FACE_POS_X;
                sc_next   = -zs;
            end
            else if (zero_next)
            begin
                face_next = FACE_POS_X;
                sc_next   = zs;
            end
            else
            begin
                face_next = FACE_NEG_X;
                sc_next   = zs;
            end
        end
        else if (ay >= az)
        begin
            ma_next = ay;
            sc_next = xs;
            if (!ys[MAG_W-1])
            begin
                face_next = FACE_POS_Y;
                tc_next   = zs;
            end
            else
            begin
                face_next = FACE_NEG_Y;
                tc_next   = -zs;
            end
        end
        else
        begin
            ma_next = az;
            tc_next = -ys;
            if (!zs[MAG_W-1])
            begin
                face_next = FACE_POS_Z;
                sc_next   = xs;
            end
            else
            begin
                face_next = FACE_NEG_Z;
                sc_next   = -xs;
            end
        end
    end

    // Offset numerators into [0, 2*ma]; the divisor is 2*ma.
    always_comb
    begin
        sum_c = (SUM_W+1)'(sc_reg) + (SUM_W+1)'($signed({1'b0, ma_reg}));
        sum_r = (SUM_W+1)'(tc_reg) + (SUM_W+1)'($signed({1'b0, ma_reg}));
    end

    // Scale by the face size and split into the divider's starting word.
    always_comb
    begin
        prod_c = (PROD_W+1)'(sumc_reg) * (PROD_W+1)'(size_eff);
        prod_r = (PROD_W+1)'(sumr_reg) * (PROD_W+1)'(size_eff);
        word_next.zero     = zero2_reg;
        word_next.face     = face2_reg;
        word_next.div      = div_reg;
        word_next.col.rem  = prod_c[PROD_W-1:QUOT_W];
        word_next.col.low  = prod_c[QUOT_W-1:0];
        word_next.col.quo  = '0;
        word_next.row.rem  = prod_r[PROD_W-1:QUOT_W];
        word_next.row.low  = prod_r[QUOT_W-1:0];
        word_next.row.quo  = '0;
    end

    // Valid bits of the three stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Payload of the three stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ma_reg    <= ma_next;
            sc_reg    <= sc_next;
            tc_reg    <= tc_next;
            face1_reg <= face_next;
            zero1_reg <= zero_next;
            sumc_reg  <= sum_c[SUM_W-1:0];
            sumr_reg  <= sum_r[SUM_W-1:0];
            div_reg   <= {ma_reg[MAG_W-2:0], 1'b0};
            face2_reg <= face1_reg;
            zero2_reg <= zero1_reg;
            word_reg  <= word_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_word  = word_reg;

endmodule

[hdl/cmfs_div_step.sv]
// One restoring division step for the column and row lanes together.
// One register stage. Depends on cmfs_pkg.
module cmfs_div_step
    import cmfs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      in_valid,
    input  cmfs_div_t in_word,
    output logic      out_valid,
    output cmfs_div_t out_word
);

    logic      valid_reg;
    cmfs_div_t word_next, word_reg;

    // Shift in the next numerator bit, subtract the divisor where it fits.
    function automatic cmfs_lane_t lane_step(input cmfs_lane_t l, input logic [DIV_W-1:0] d);
        logic [REM_W:0] t;
        cmfs_lane_t     r;
        t = {l.rem, l.low[QUOT_W-1]};
        if (t >= d)
        begin
            r.rem = REM_W'(t - d);
            r.quo = {l.quo[QUOT_W-2:0], 1'b1};
        end
        else
        begin
            r.rem = t[REM_W-1:0];
            r.quo = {l.quo[QUOT_W-2:0], 1'b0};
        end
        r.low = {l.low[QUOT_W-2:0], 1'b0};
        return r;
    endfunction

    always_comb
    begin
        word_next     = in_word;
        word_next.col = lane_step(in_word.col, in_word.div);
        word_next.row = lane_step(in_word.row, in_word.div);
    end

    // Valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (en)
            word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

[hdl/cmfs_texel_out.sv]
// Back of the pipeline: clamp to the face edge, texel index multiply and
// the output register. Two register stages. Depends on cmfs_pkg.
module cmfs_texel_out
    import cmfs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  cmfs_div_t            in_word,
    input  logic [FSIZE_W-1:0]   size_eff,
    output logic                 out_valid,
    output logic [2:0]           face,
    output logic [COORD_W-1:0]   texel_col,
    output logic [COORD_W-1:0]   texel_row,
    output logic [INDEX_W-1:0]   texel_index,
    output logic                 zero_dir
);

    logic [FSIZE_W-1:0] size_m1;
    logic [COORD_W-1:0] col_next, row_next;
    logic [INDEX_W:0]   idx_prod;
    logic [INDEX_W-1:0] idx_next;

    logic               vc_reg, vo_reg;
    logic [COORD_W-1:0] colc_reg, rowc_reg;
    face_t              facec_reg;
    logic               zeroc_reg;

    logic [2:0]         face_reg;
    logic [COORD_W-1:0] col_reg, row_reg;
    logic [INDEX_W-1:0] idx_reg;
    logic               zero_reg;

    // Clamp an exact edge hit to size minus one; a zero vector reads as 0.
    always_comb
    begin
        size_m1 = size_eff - FSIZE_W'(1);
        if (in_word.zero)
        begin
            col_next = '0;
            row_next = '0;
        end
        else
        begin
            col_next = (in_word.col.quo > size_m1) ? size_m1[COORD_W-1:0]
                                                   : in_word.col.quo[COORD_W-1:0];
            row_next = (in_word.row.quo > size_m1) ? size_m1[COORD_W-1:0]
                                                   : in_word.row.quo[COORD_W-1:0];
        end
    end

    // Texel index within the face.
    always_comb
    begin
        idx_prod = (INDEX_W+1)'(rowc_reg) * (INDEX_W+1)'(size_eff);
        idx_next = idx_prod[INDEX_W-1:0] + INDEX_W'(colc_reg);
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            vc_reg <= in_valid;
            vo_reg <= vc_reg;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            colc_reg  <= col_next;
            rowc_reg  <= row_next;
            facec_reg <= in_word.face;
            zeroc_reg <= in_word.zero;
            face_reg  <= facec_reg;
            col_reg   <= colc_reg;
            row_reg   <= rowc_reg;
            idx_reg   <= idx_next;
            zero_reg  <= zeroc_reg;
        end
    end

    assign out_valid   = vo_reg;
    assign face        = face_reg;
    assign texel_col   = col_reg;
    assign texel_row   = row_reg;
    assign texel_index = idx_reg;
    assign zero_dir    = zero_reg;

endmodule

[hdl/cube_map_face_select_unit.sv]
// A word accepted at a clock edge reaches m_tdata through 18 register stages
// (3 front, 13 divider steps, clamp, output register).
// Throughput: one word per cycle unless the output stalls; the thirteen one-bit
// division steps per lane each hold their own stage, so a new word may enter every cycle.
// A stall on the output freezes every stage together; nothing is dropped.
// Reset clears all valid bits at once and loads face_size with 256.
module cube_map_face_select_unit
    import cmfs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // Configuration: face_size write.
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [FSIZE_W-1:0]  cfg_data,
    // Input stream.
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [47:0]         s_tdata,   // dir_x[15:0], dir_y[31:16], dir_z[47:32]
    // Output stream.
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [55:0]         m_tdata,   // face[2:0], texel_col[14:3],
                                           // texel_row[26:15], texel_index[50:27]
    output logic [0:0]          m_tuser    // zero_dir[0]
);

    localparam int NSTEP = QUOT_W;

    logic [FSIZE_W-1:0] size_reg;
    logic [FSIZE_W-1:0] size_eff;
    logic               en;

    logic               front_valid;
    cmfs_div_t          front_word;
    logic               step_valid [NSTEP+1];
    cmfs_div_t          step_word  [NSTEP+1];

    logic [2:0]         face;
    logic [COORD_W-1:0] texel_col, texel_row;
    logic [INDEX_W-1:0] texel_index;
    logic               zero_dir;

    // Face size register; writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            size_reg <= FSIZE_W'(FACE_SIZE_RESET);
        else if (cfg_valid)
            size_reg <= cfg_data;
    end

    assign size_eff = sat_face_size(size_reg);

    // The whole pipeline advances unless a finished word is held at the output.
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    cmfs_major_axis u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .dir_x     ($signed(s_tdata[15:0])),
        .dir_y     ($signed(s_tdata[31:16])),
        .dir_z     ($signed(s_tdata[47:32])),
        .size_eff  (size_eff),
        .out_valid (front_valid),
        .out_word  (front_word)
    );

    assign step_valid[0] = front_valid;
    assign step_word[0]  = front_word;

    // One quotient bit per stage for both lanes.
    for (genvar i = 0; i < NSTEP; i++)
    begin : g_div
        cmfs_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (step_valid[i]),
            .in_word   (step_word[i]),
            .out_valid (step_valid[i+1]),
            .out_word  (step_word[i+1])
        );
    end

    cmfs_texel_out u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (step_valid[NSTEP]),
        .in_word     (step_word[NSTEP]),
        .size_eff    (size_eff),
        .out_valid   (m_tvalid),
        .face        (face),
        .texel_col   (texel_col),
        .texel_row   (texel_row),
        .texel_index (texel_index),
        .zero_dir    (zero_dir)
    );

    // Output packing.
    assign m_tdata = {5'b0, texel_index, texel_row, texel_col, face};
    assign m_tuser = zero_dir;

endmodule

[hdl/cmfs_checker.sv]
// Port-level checks for the cube map face select unit, bound to the top level.
// Depends on cube_map_face_select_unit's port list only.
module cmfs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // A word held back by the sink stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

    // The input side is open exactly when the output stage can move.
    a_ready_link: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stage");

    // A zero vector yields face 0 at texel 0.
    a_zero_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[50:0] == 51'd0)
        else $error("zero direction word carries non-zero fields");

    // Only six faces exist.
    a_face_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[2:0] != 3'd6 && m_tdata[2:0] != 3'd7)
        else $error("face code out of range");

endmodule

bind cube_map_face_select_unit cmfs_checker u_cmfs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
